/* hw/rtl/svlr_pkg.sv */
// Shared types and constants of the sample playback voice.
package svlr_pkg;

	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 16;
	localparam int CMD_DEPTH   = 4;
	localparam int OUT_DEPTH   = 8;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_START  = 2'd1,
		ACT_STOP   = 2'd2,
		ACT_RENDER = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_SOURCE_LENGTH = 2'd0,
		REG_STEP_RATE     = 2'd1,
		REG_GAIN          = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_PLAYING  = 2'd1,
		MODE_STOPPING = 2'd2
	} voice_mode_t;

	typedef struct packed {
		action_t            action;
		logic [15:0]        load_index;
		logic signed [15:0] load_left;
		logic signed [15:0] load_right;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic               voice_active;
	} out_item_t;

	// Work passed from the front part to the back part, in item order.
	typedef struct packed {
		logic               is_load;
		logic [16:0]        index;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [15:0]        frac;
		logic               active;
		logic               audible;
	} cmd_t;

endpackage

/* hw/rtl/sample_voice_linear_resampler.sv */
// Top level of the stereo linear-interpolation sample playback voice.
//
// Usage:
//   Input channel: drive item and push; the item is taken at a clock edge
//   with push high and full low. Load items fill the frame store, start
//   rewinds the read position and plays, stop silences the next render and
//   returns to idle, render produces exactly one result item.
//   Result channel: while empty is low the oldest result sits on result;
//   it is taken at a clock edge with pop high.
//   Configuration: wr_en with wr_index and wr_data writes source_length,
//   step_rate or gain; write only while no item is in flight.
// Timing:
//   One item is taken per cycle while full is low. A render item is pushed
//   into the command queue, popped as the frame store is read, registered
//   after interpolation and after gain, and rounded into the result queue.
//   When pop stays low the result queue fills, renders wait in the command
//   queue and full rises once it fills.
// Reset:
//   Position clears, the voice goes idle, registers take their defaults.
//   The frame store is not cleared; frames must be loaded before use.
module sample_voice_linear_resampler #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  svlr_pkg::in_item_t   item,
	output logic                 full,
	input  logic                 pop,
	output svlr_pkg::out_item_t  result,
	output logic                 empty,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [23:0]          wr_data
);

	logic [16:0] source_length_q;
	logic [23:0] step_rate_q;
	logic [15:0] gain_q;

	logic           accept;
	logic           cmd_push;
	svlr_pkg::cmd_t cmd_in;
	svlr_pkg::cmd_t cmd_out;
	logic           cmd_full;
	logic           cmd_empty;
	logic           cmd_pop;

	// Take an item whenever the command queue has space.
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Configuration registers; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_length_q <= 17'd0;
			step_rate_q     <= 24'd65536;
			gain_q          <= 16'd16384;
		end else if (wr_en) begin
			case (wr_index)
				svlr_pkg::REG_SOURCE_LENGTH: source_length_q <= wr_data[16:0];
				svlr_pkg::REG_STEP_RATE:     step_rate_q     <= wr_data;
				svlr_pkg::REG_GAIN:          gain_q          <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	svlr_front #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.source_length (source_length_q),
		.step_rate     (step_rate_q),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	// Decouple the front from the back; loads and renders keep their order.
	svlr_fifo #(
		.WIDTH ($bits(svlr_pkg::cmd_t)),
		.DEPTH (svlr_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.data_in  (cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.data_out (cmd_out),
		.empty    (cmd_empty)
	);

	svlr_back #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.gain      (gain_q),
		.pop       (pop),
		.result    (result),
		.empty     (empty)
	);

endmodule

/* hw/rtl/svlr_fifo.sv */
// Small first-in first-out queue with a registered count.
module svlr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] data_in,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] data_out,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/svlr_front.sv */
// Front part: classifies items, keeps voice mode and read position, issues work.
module svlr_front #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  svlr_pkg::in_item_t  item,
	input  logic [16:0]         source_length,
	input  logic [23:0]         step_rate,
	output logic                cmd_push,
	output svlr_pkg::cmd_t      cmd
);

	svlr_pkg::voice_mode_t mode_q;
	svlr_pkg::voice_mode_t mode_d;
	logic [32:0]           pos_q;
	logic [32:0]           pos_d;
	logic [33:0]           pos_sum;
	logic [32:0]           pos_sat;
	logic [17:0]           idx_p1;
	logic                  in_range;
	logic                  load_ok;

	assign pos_sum  = {1'b0, pos_q} + 34'(step_rate);
	assign pos_sat  = pos_sum[33] ? '1 : pos_sum[32:0];
	assign idx_p1   = 18'(pos_q[32:16]) + 18'd1;
	assign in_range = (idx_p1 < 18'(source_length)) && (32'(idx_p1) < 32'(MAX_FRAMES));
	assign load_ok  = 32'(item.load_index) < 32'(MAX_FRAMES);

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		cmd      = '0;
		cmd_push = 1'b0;
		case (item.action)
			svlr_pkg::ACT_LOAD: begin
				cmd.is_load = 1'b1;
				cmd.index   = 17'(item.load_index);
				cmd.left    = item.load_left;
				cmd.right   = item.load_right;
				cmd_push    = accept && load_ok;
			end
			svlr_pkg::ACT_START: begin
				pos_d  = '0;
				mode_d = svlr_pkg::MODE_PLAYING;
			end
			svlr_pkg::ACT_STOP: begin
				mode_d = svlr_pkg::MODE_STOPPING;
			end
			svlr_pkg::ACT_RENDER: begin
				cmd_push = accept;
				if (mode_q == svlr_pkg::MODE_PLAYING) begin
					cmd.active  = 1'b1;
					cmd.index   = pos_q[32:16];
					cmd.frac    = pos_q[15:0];
					cmd.audible = in_range;
					pos_d       = pos_sat;
				end else if (mode_q == svlr_pkg::MODE_STOPPING) begin
					mode_d = svlr_pkg::MODE_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= svlr_pkg::MODE_IDLE;
			pos_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
		end
	end

endmodule

/* hw/rtl/svlr_back.sv */
// Back part: frame store, interpolation and gain pipeline, result queue.
module svlr_back #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_empty,
	input  svlr_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	input  logic [15:0]          gain,
	input  logic                 pop,
	output svlr_pkg::out_item_t  result,
	output logic                 empty
);

	localparam int AW  = $clog2(MAX_FRAMES);
	localparam int WW  = svlr_pkg::CHANNELS * svlr_pkg::SAMPLE_BITS;
	localparam int SB  = svlr_pkg::SAMPLE_BITS;
	localparam int PCW = $clog2(svlr_pkg::OUT_DEPTH + 1);

	logic [WW-1:0] frame_mem [MAX_FRAMES];

	logic          issue;
	logic          issue_render;
	logic          room;
	logic          res_pop;
	logic [PCW-1:0] pend_q;

	// stage 1: store read data
	logic          vld_s1;
	logic [WW-1:0] rd0_s1;
	logic [WW-1:0] rd1_s1;
	logic [15:0]   frac_s1;
	logic          active_s1;
	logic          audible_s1;
	// stage 2: interpolated samples
	logic          vld_s2;
	logic          active_s2;
	logic          audible_s2;
	logic signed [33:0] interp_s2 [svlr_pkg::CHANNELS];
	// stage 3: gain product
	logic          vld_s3;
	logic          active_s3;
	logic          audible_s3;
	logic signed [50:0] prod_s3 [svlr_pkg::CHANNELS];

	logic signed [16:0] diff   [svlr_pkg::CHANNELS];
	logic signed [33:0] slope  [svlr_pkg::CHANNELS];
	logic signed [33:0] interp [svlr_pkg::CHANNELS];
	logic signed [50:0] prod   [svlr_pkg::CHANNELS];
	logic signed [50:0] rnd    [svlr_pkg::CHANNELS];
	logic signed [50:0] quot   [svlr_pkg::CHANNELS];
	logic [15:0]        sat    [svlr_pkg::CHANNELS];
	logic signed [16:0] frac_sx;
	logic signed [16:0] gain_sx;

	svlr_pkg::out_item_t res_d;
	logic                res_full;

	// Renders only issue while the result queue has a slot reserved for them.
	assign room         = (pend_q != PCW'(svlr_pkg::OUT_DEPTH));
	assign issue        = !cmd_empty && (cmd.is_load || room);
	assign issue_render = issue && !cmd.is_load;
	assign cmd_pop      = issue;
	assign res_pop      = pop && !empty;

	always_ff @(posedge clk) begin
		if (issue && cmd.is_load) begin
			frame_mem[AW'(cmd.index)] <= {cmd.right, cmd.left};
		end
		rd0_s1 <= frame_mem[AW'(cmd.index)];
		rd1_s1 <= frame_mem[AW'(cmd.index + 17'd1)];
	end

	assign frac_sx = $signed({1'b0, frac_s1});
	assign gain_sx = $signed({1'b0, gain});

	always_comb begin
		for (int c = 0; c < svlr_pkg::CHANNELS; c++) begin
			diff[c]   = 17'($signed(rd1_s1[c*SB +: SB])) - 17'($signed(rd0_s1[c*SB +: SB]));
			slope[c]  = 34'(diff[c]) * 34'(frac_sx);
			interp[c] = (34'($signed(rd0_s1[c*SB +: SB])) <<< 16) + slope[c];
			prod[c]   = 51'(interp_s2[c]) * 51'(gain_sx);
			rnd[c]    = prod_s3[c] + 51'sd536870912;
			quot[c]   = rnd[c] >>> 30;
			if ((quot[c][50:15] == '0) || (quot[c][50:15] == '1)) begin
				sat[c] = quot[c][15:0];
			end else if (quot[c][50]) begin
				sat[c] = 16'h8000;
			end else begin
				sat[c] = 16'h7FFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		frac_s1    <= cmd.frac;
		active_s1  <= cmd.active;
		audible_s1 <= cmd.audible;
		active_s2  <= active_s1;
		audible_s2 <= audible_s1;
		active_s3  <= active_s2;
		audible_s3 <= audible_s2;
		for (int c = 0; c < svlr_pkg::CHANNELS; c++) begin
			interp_s2[c] <= interp[c];
			prod_s3[c]   <= prod[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			pend_q <= '0;
		end else begin
			vld_s1 <= issue_render;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (issue_render && !res_pop) begin
				pend_q <= pend_q + 1'b1;
			end else if (res_pop && !issue_render) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	always_comb begin
		res_d              = '0;
		res_d.voice_active = active_s3;
		if (audible_s3) begin
			res_d.out_left  = sat[0];
			res_d.out_right = sat[svlr_pkg::CHANNELS - 1];
		end
	end

	// The reservation count already keeps the queue from overflowing.
	svlr_fifo #(
		.WIDTH ($bits(svlr_pkg::out_item_t)),
		.DEPTH (svlr_pkg::OUT_DEPTH)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (vld_s3 && !res_full),
		.data_in  (res_d),
		.full     (res_full),
		.pop      (pop),
		.data_out (result),
		.empty    (empty)
	);

endmodule
